// ----- rtl/csvt_pkg.sv -----
// Shared types, character codes and result kinds for the CSV byte tokenizer.
// No dependencies.
package csvt_pkg;

    localparam logic       MODE_TEXT = 1'b0;
    localparam logic       MODE_EOT  = 1'b1;

    localparam logic [1:0] KIND_CHAR      = 2'd0;
    localparam logic [1:0] KIND_FIELD_END = 2'd1;
    localparam logic [1:0] KIND_ROW_END   = 2'd2;

    localparam logic [7:0] BOM_BYTE0 = 8'hEF;
    localparam logic [7:0] BOM_BYTE1 = 8'hBB;
    localparam logic [7:0] BOM_BYTE2 = 8'hBF;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HT    = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic       eot;
        logic [7:0] text_byte;
        logic       item_last;
    } t_uop;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] char_out;
        logic       field_was_quoted;
        logic       trim_overflow;
    } t_res;

    typedef struct packed {
        logic vld;
        logic done;
        t_res res;
    } t_gen;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_HT) || (c == CH_VT) || (c == CH_FF);
    endfunction

    function automatic t_res make_char(input logic [7:0] c, input logic ovf);
        t_res r;
        r.kind             = KIND_CHAR;
        r.char_out         = c;
        r.field_was_quoted = 1'b0;
        r.trim_overflow    = ovf;
        return r;
    endfunction

    function automatic t_res make_end(input logic [1:0] kind, input logic quoted);
        t_res r;
        r.kind             = kind;
        r.char_out         = 8'h00;
        r.field_was_quoted = quoted;
        r.trim_overflow    = 1'b0;
        return r;
    endfunction

endpackage

// ----- rtl/csvt_if.sv -----
// Valid/ready channel interfaces for text input and token output.
// No dependencies.
interface csvt_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] text_byte;

    modport source (output valid, output mode, output text_byte, input ready);
    modport sink   (input valid, input mode, input text_byte, output ready);
endinterface

interface csvt_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] char_out;
    logic       field_was_quoted;
    logic       trim_overflow;
    logic       last;

    modport source (output valid, output kind, output char_out, output field_was_quoted,
                    output trim_overflow, output last, input ready);
    modport sink   (input valid, input kind, input char_out, input field_was_quoted,
                    input trim_overflow, input last, output ready);
endinterface

// ----- rtl/csv_byte_tokenizer_core.sv -----
// Path: operation queue, back end, result staging register and output register.
// Throughput: one text byte and one result per cycle while the output accepts and neither
// end is busy; flushing held whitespace, a full whitespace buffer or a partial byte order
// mark stall the input. The back-end sequencer and the buffer RAM read set the rate.
// Reset: synchronous active low; clears all control state, buffer contents stay undefined.
// Depends on csvt_pkg, csvt_if, csvt_ram, csvt_queue, csvt_front, csvt_back, csvt_emit.
module csv_byte_tokenizer_core #(
    parameter int MAX_PENDING_SPACE = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    csvt_in_if.sink    i_text,
    csvt_out_if.source o_tok
);
    import csvt_pkg::*;

    logic push_valid;
    logic push_ready;
    t_uop push_data;
    logic pop_valid;
    logic pop_ready;
    t_uop pop_data;
    t_gen gen;
    logic gen_ready;

    csvt_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_text       (i_text),
        .o_push_valid (push_valid),
        .o_push_data  (push_data),
        .i_push_ready (push_ready)
    );

    csvt_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_data  (push_data),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_data   (pop_data),
        .i_pop_ready  (pop_ready)
    );

    csvt_back #(
        .MAX_PENDING_SPACE (MAX_PENDING_SPACE)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_uop_valid (pop_valid),
        .i_uop       (pop_data),
        .o_uop_pop   (pop_ready),
        .o_gen       (gen),
        .i_gen_ready (gen_ready)
    );

    csvt_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_gen       (gen),
        .o_gen_ready (gen_ready),
        .o_tok       (o_tok)
    );
endmodule

// ----- rtl/csvt_ram.sv -----
// Generic single write port RAM with one registered read port.
// No dependencies.
module csvt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                     i_wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                     o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
endmodule

// ----- rtl/csvt_queue.sv -----
// Short FIFO of byte operations between the front and back ends.
// Depends on csvt_pkg.
module csvt_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    input  csvt_pkg::t_uop i_push_data,
    output logic          o_push_ready,
    output logic          o_pop_valid,
    output csvt_pkg::t_uop o_pop_data,
    input  logic          i_pop_ready
);
    import csvt_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_uop          r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [CW-1:0] r_cnt;
    logic          push;
    logic          pop;

    assign o_push_ready = (r_cnt != CW'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_data   = r_mem[r_rp];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop_ready && o_pop_valid;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return ((PW + 1)'(p) + (PW + 1)'(1) == (PW + 1)'(QUEUE_DEPTH)) ? '0 : p + PW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= ptr_inc(r_wp);
            end
            if (pop) begin
                r_rp <= ptr_inc(r_rp);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end
endmodule

// ----- rtl/csvt_front.sv -----
// Front end: accepts input transactions, tracks the byte order mark and
// replays a partial mark as data. Depends on csvt_pkg and csvt_in_if.
module csvt_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    csvt_in_if.sink        i_text,
    output logic           o_push_valid,
    output csvt_pkg::t_uop o_push_data,
    input  logic           i_push_ready
);
    import csvt_pkg::*;

    localparam logic [1:0] BOM_EXPECT = 2'd0;
    localparam logic [1:0] BOM_SAW0   = 2'd1;
    localparam logic [1:0] BOM_SAW1   = 2'd2;
    localparam logic [1:0] BOM_PAST   = 2'd3;

    logic [1:0] r_bom,      n_bom;
    logic       r_busy,     n_busy;
    logic       r_bb,       n_bb;
    logic       r_fin_eot,  n_fin_eot;
    logic [7:0] r_fin_byte, n_fin_byte;
    logic       acc;
    logic [7:0] c;

    assign i_text.ready = !r_busy && i_push_ready;
    assign acc          = i_text.valid && i_text.ready;
    assign c            = i_text.text_byte;

    always_comb begin
        n_bom        = r_bom;
        n_busy       = r_busy;
        n_bb         = r_bb;
        n_fin_eot    = r_fin_eot;
        n_fin_byte   = r_fin_byte;
        o_push_valid = 1'b0;
        o_push_data  = '{eot: 1'b0, text_byte: c, item_last: 1'b1};
        if (r_busy) begin
            o_push_valid = 1'b1;
            if (r_bb) begin
                o_push_data = '{eot: 1'b0, text_byte: BOM_BYTE1, item_last: 1'b0};
                if (i_push_ready) begin
                    n_bb = 1'b0;
                end
            end else begin
                o_push_data = '{eot: r_fin_eot, text_byte: r_fin_byte, item_last: 1'b1};
                if (i_push_ready) begin
                    n_busy = 1'b0;
                end
            end
        end else if (acc) begin
            if (i_text.mode == MODE_EOT) begin
                n_bom        = BOM_EXPECT;
                o_push_valid = 1'b1;
                if (r_bom == BOM_SAW0 || r_bom == BOM_SAW1) begin
                    o_push_data = '{eot: 1'b0, text_byte: BOM_BYTE0, item_last: 1'b0};
                    n_busy      = 1'b1;
                    n_bb        = (r_bom == BOM_SAW1);
                    n_fin_eot   = 1'b1;
                    n_fin_byte  = c;
                end else begin
                    o_push_data = '{eot: 1'b1, text_byte: c, item_last: 1'b1};
                end
            end else begin
                case (r_bom)
                    BOM_EXPECT: begin
                        if (c == BOM_BYTE0) begin
                            n_bom = BOM_SAW0;
                        end else begin
                            n_bom        = BOM_PAST;
                            o_push_valid = 1'b1;
                        end
                    end
                    BOM_SAW0, BOM_SAW1: begin
                        if ((r_bom == BOM_SAW0 && c == BOM_BYTE1)) begin
                            n_bom = BOM_SAW1;
                        end else if (r_bom == BOM_SAW1 && c == BOM_BYTE2) begin
                            n_bom = BOM_PAST;
                        end else begin
                            n_bom        = BOM_PAST;
                            o_push_valid = 1'b1;
                            o_push_data  = '{eot: 1'b0, text_byte: BOM_BYTE0, item_last: 1'b0};
                            n_busy       = 1'b1;
                            n_bb         = (r_bom == BOM_SAW1);
                            n_fin_eot    = 1'b0;
                            n_fin_byte   = c;
                        end
                    end
                    default: begin
                        o_push_valid = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_fin_eot  <= n_fin_eot;
        r_fin_byte <= n_fin_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bom  <= BOM_EXPECT;
            r_busy <= 1'b0;
            r_bb   <= 1'b0;
        end else begin
            r_bom  <= n_bom;
            r_busy <= n_busy;
            r_bb   <= n_bb;
        end
    end
endmodule

// ----- rtl/csvt_back.sv -----
// Back end: quote and field state machine with the trailing whitespace
// buffer. Depends on csvt_pkg and csvt_ram.
module csvt_back #(
    parameter int MAX_PENDING_SPACE = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_uop_valid,
    input  csvt_pkg::t_uop i_uop,
    output logic           o_uop_pop,
    output csvt_pkg::t_gen o_gen,
    input  logic           i_gen_ready
);
    import csvt_pkg::*;

    localparam int AW = (MAX_PENDING_SPACE > 1) ? $clog2(MAX_PENDING_SPACE) : 1;
    localparam int CW = $clog2(MAX_PENDING_SPACE + 1);
    localparam int SW = ((AW > CW) ? AW : CW) + 1;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_FLUSH = 2'd1;
    localparam logic [1:0] S_TAIL  = 2'd2;
    localparam logic [1:0] S_OVF   = 2'd3;

    logic [1:0]    r_state, n_state;
    logic          r_iq,    n_iq;
    logic          r_qla,   n_qla;
    logic          r_fqf,   n_fqf;
    logic          r_ols,   n_ols;
    logic          r_fea,   n_fea;
    logic          r_rhf,   n_rhf;
    logic [AW-1:0] r_head,  n_head;
    logic [CW-1:0] r_cnt,   n_cnt;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] tail;
    logic [AW-1:0] head_inc;
    logic [SW-1:0] tail_sum;
    logic [7:0]    rd_data;
    logic [7:0]    c;
    logic          complete;
    logic          has_row;

    assign c        = i_uop.text_byte;
    assign has_row  = r_rhf || r_fqf || r_fea;
    assign tail_sum = SW'(r_head) + SW'(r_cnt);
    assign tail     = (tail_sum >= SW'(MAX_PENDING_SPACE)) ?
                      AW'(tail_sum - SW'(MAX_PENDING_SPACE)) : AW'(tail_sum);
    assign head_inc = (SW'(r_head) + SW'(1) == SW'(MAX_PENDING_SPACE)) ?
                      '0 : r_head + AW'(1);

    csvt_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PENDING_SPACE)
    ) u_pending (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (c),
        .i_rd_addr (n_head),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_state   = r_state;
        n_iq      = r_iq;
        n_qla     = r_qla;
        n_fqf     = r_fqf;
        n_ols     = r_ols;
        n_fea     = r_fea;
        n_rhf     = r_rhf;
        n_head    = r_head;
        n_cnt     = r_cnt;
        wr_en     = 1'b0;
        wr_addr   = tail;
        complete  = 1'b0;
        o_gen.vld = 1'b0;
        o_gen.res = make_char(c, 1'b0);
        case (r_state)
            S_IDLE: begin
                if (i_uop_valid) begin
                    if (i_uop.eot) begin
                        o_gen.vld = has_row;
                        o_gen.res = make_end(KIND_ROW_END, r_fqf);
                        if (!has_row || i_gen_ready) begin
                            complete = 1'b1;
                            n_iq     = 1'b0;
                            n_qla    = 1'b0;
                            n_rhf    = 1'b0;
                            n_fqf    = 1'b0;
                            n_ols    = 1'b1;
                            n_fea    = 1'b0;
                            n_cnt    = '0;
                        end
                    end else if (r_qla && c == CH_QUOTE) begin
                        o_gen.vld = 1'b1;
                        if (i_gen_ready) begin
                            complete = 1'b1;
                            n_qla    = 1'b0;
                            n_fea    = 1'b1;
                        end
                    end else if (r_iq && !r_qla) begin
                        if (c == CH_QUOTE) begin
                            complete = 1'b1;
                            n_qla    = 1'b1;
                        end else begin
                            o_gen.vld = 1'b1;
                            if (i_gen_ready) begin
                                complete = 1'b1;
                                n_fea    = 1'b1;
                            end
                        end
                    end else begin
                        // close any quoted section; the unquoted path does not read it
                        n_qla = 1'b0;
                        n_iq  = 1'b0;
                        if (c == CH_COMMA) begin
                            o_gen.vld = 1'b1;
                            o_gen.res = make_end(KIND_FIELD_END, r_fqf);
                            if (i_gen_ready) begin
                                complete = 1'b1;
                                n_fqf    = 1'b0;
                                n_ols    = 1'b1;
                                n_fea    = 1'b0;
                                n_cnt    = '0;
                                n_rhf    = 1'b1;
                            end
                        end else if (c == CH_CR) begin
                            complete = 1'b1;
                        end else if (c == CH_LF) begin
                            o_gen.vld = has_row;
                            o_gen.res = make_end(KIND_ROW_END, r_fqf);
                            if (!has_row || i_gen_ready) begin
                                complete = 1'b1;
                                n_fqf    = 1'b0;
                                n_ols    = 1'b1;
                                n_fea    = 1'b0;
                                n_cnt    = '0;
                                n_rhf    = 1'b0;
                            end
                        end else if (c == CH_QUOTE && r_ols && !r_fqf) begin
                            complete = 1'b1;
                            n_iq     = 1'b1;
                            n_fqf    = 1'b1;
                            n_ols    = 1'b0;
                            n_cnt    = '0;
                        end else if (r_fqf) begin
                            o_gen.vld = 1'b1;
                            if (i_gen_ready) begin
                                complete = 1'b1;
                                n_fea    = 1'b1;
                            end
                        end else if (is_ws(c)) begin
                            if (r_ols) begin
                                complete = 1'b1;
                            end else if (r_cnt == CW'(MAX_PENDING_SPACE)) begin
                                n_state = S_OVF;
                            end else begin
                                complete = 1'b1;
                                wr_en    = 1'b1;
                                n_cnt    = r_cnt + CW'(1);
                            end
                        end else if (r_cnt != '0) begin
                            n_state = S_FLUSH;
                        end else begin
                            o_gen.vld = 1'b1;
                            if (i_gen_ready) begin
                                complete = 1'b1;
                                n_fea    = 1'b1;
                                n_ols    = 1'b0;
                            end
                        end
                    end
                end
            end
            S_FLUSH: begin
                o_gen.vld = 1'b1;
                o_gen.res = make_char(rd_data, 1'b0);
                if (i_gen_ready) begin
                    n_head = head_inc;
                    n_cnt  = r_cnt - CW'(1);
                    n_fea  = 1'b1;
                    if (r_cnt == CW'(1)) begin
                        n_state = S_TAIL;
                    end
                end
            end
            S_TAIL: begin
                o_gen.vld = 1'b1;
                if (i_gen_ready) begin
                    complete = 1'b1;
                    n_fea    = 1'b1;
                    n_ols    = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            S_OVF: begin
                o_gen.vld = 1'b1;
                o_gen.res = make_char(rd_data, 1'b1);
                wr_addr   = r_head;
                if (i_gen_ready) begin
                    complete = 1'b1;
                    wr_en    = 1'b1;
                    n_head   = head_inc;
                    n_fea    = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        o_gen.done = complete && i_uop.item_last;
    end

    assign o_uop_pop = complete;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_iq    <= 1'b0;
            r_qla   <= 1'b0;
            r_fqf   <= 1'b0;
            r_ols   <= 1'b1;
            r_fea   <= 1'b0;
            r_rhf   <= 1'b0;
            r_head  <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_iq    <= n_iq;
            r_qla   <= n_qla;
            r_fqf   <= n_fqf;
            r_ols   <= n_ols;
            r_fea   <= n_fea;
            r_rhf   <= n_rhf;
            r_head  <= n_head;
            r_cnt   <= n_cnt;
        end
    end
endmodule

// ----- rtl/csvt_emit.sv -----
// Result staging and output register; marks the last result of each input
// transaction. Depends on csvt_pkg and csvt_out_if.
module csvt_emit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  csvt_pkg::t_gen i_gen,
    output logic           o_gen_ready,
    csvt_out_if.source     o_tok
);
    import csvt_pkg::*;

    logic r_stg_valid;
    logic r_stg_last;
    t_res r_stg_res;
    logic r_out_valid;
    logic r_out_last;
    t_res r_out_res;
    logic out_free;
    logic acc;
    logic mv;

    assign out_free    = !r_out_valid || o_tok.ready;
    assign o_gen_ready = !r_stg_valid || out_free;
    assign acc         = i_gen.vld && o_gen_ready;
    assign mv          = r_stg_valid && out_free && (r_stg_last || acc);

    assign o_tok.valid            = r_out_valid;
    assign o_tok.kind             = r_out_res.kind;
    assign o_tok.char_out         = r_out_res.char_out;
    assign o_tok.field_was_quoted = r_out_res.field_was_quoted;
    assign o_tok.trim_overflow    = r_out_res.trim_overflow;
    assign o_tok.last             = r_out_last;

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_stg_res <= i_gen.res;
        end
        if (mv) begin
            r_out_res  <= r_stg_res;
            r_out_last <= r_stg_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg_valid <= 1'b0;
            r_stg_last  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (mv) begin
                r_out_valid <= 1'b1;
            end else if (o_tok.ready) begin
                r_out_valid <= 1'b0;
            end
            if (acc) begin
                r_stg_valid <= 1'b1;
                r_stg_last  <= i_gen.done;
            end else if (mv) begin
                r_stg_valid <= 1'b0;
            end else if (i_gen.done && r_stg_valid) begin
                // close the transaction on the newest held result
                r_stg_last <= 1'b1;
            end
        end
    end
endmodule

// ----- tb/sv/csv_byte_tokenizer_core_checker.sv -----
// Token checker for the CSV byte tokenizer: tracks the tokenizer state on every text
// transaction, queues the tokens it must produce and compares each accepted token.
// Depends on csvt_pkg and csvt_if.
module csv_byte_tokenizer_core_checker #(
    parameter int MAX_PENDING_SPACE = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    csvt_in_if   i_text,
    csvt_out_if  i_tok,
    output int   o_fail_count,
    output int   o_expected_left,
    output int   o_tokens_checked,
    output int   o_overflow_tokens
);
    import csvt_pkg::*;

    localparam int MAX_PRINTED = 100;

    typedef enum logic [1:0] {
        BOM_EXPECT_EF,
        BOM_SAW_EF,
        BOM_SAW_EF_BB,
        BOM_PAST
    } t_bom_pos;

    typedef struct packed {
        t_res res;
        logic last;
    } t_token;

    t_token     expected_tokens [$];
    t_res       step_tokens [$];
    logic       in_string;
    logic       quote_peek;
    logic       field_quoted;
    logic       leading_only;
    logic       field_has_text;
    logic       row_open;
    t_bom_pos   bom_pos;
    logic [7:0] held_ws [MAX_PENDING_SPACE];
    int         held_n;
    int         fail_count;
    int         tokens_checked;
    int         overflow_tokens;

    function automatic void push_token(logic [1:0] kind, logic [7:0] ch, logic quoted,
                                       logic ovf);
        t_res r;
        r.kind             = kind;
        r.char_out         = ch;
        r.field_was_quoted = quoted;
        r.trim_overflow    = ovf;
        step_tokens.insert(step_tokens.size(), r);
    endfunction

    function automatic void put_char(logic [7:0] c);
        push_token(KIND_CHAR, c, 1'b0, 1'b0);
        field_has_text = 1'b1;
    endfunction

    function automatic void open_field();
        field_quoted   = 1'b0;
        leading_only   = 1'b1;
        field_has_text = 1'b0;
        held_n         = 0;
    endfunction

    function automatic void finish_row();
        if (row_open || field_quoted || field_has_text) begin
            push_token(KIND_ROW_END, 8'h00, field_quoted, 1'b0);
        end
        open_field();
        row_open = 1'b0;
    endfunction

    function automatic void reset_tracker();
        in_string  = 1'b0;
        quote_peek = 1'b0;
        row_open   = 1'b0;
        bom_pos    = BOM_EXPECT_EF;
        open_field();
    endfunction

    function automatic void plain_byte(logic [7:0] c);
        if (c == CH_CR) begin
            return;
        end
        if (c == CH_COMMA) begin
            push_token(KIND_FIELD_END, 8'h00, field_quoted, 1'b0);
            open_field();
            row_open = 1'b1;
        end else if (c == CH_LF) begin
            finish_row();
        end else if (c == CH_QUOTE && leading_only && !field_quoted) begin
            in_string    = 1'b1;
            field_quoted = 1'b1;
            leading_only = 1'b0;
            held_n       = 0;
        end else if (field_quoted) begin
            put_char(c);
        end else if (c inside {CH_SPACE, CH_HT, CH_VT, CH_FF}) begin
            if (leading_only) begin
                return;
            end
            if (held_n >= MAX_PENDING_SPACE) begin
                push_token(KIND_CHAR, held_ws[0], 1'b0, 1'b1);
                field_has_text = 1'b1;
                for (int i = 0; i < MAX_PENDING_SPACE - 1; i++) begin
                    held_ws[i] = held_ws[i + 1];
                end
                held_ws[MAX_PENDING_SPACE - 1] = c;
            end else begin
                held_ws[held_n] = c;
                held_n++;
            end
        end else begin
            for (int i = 0; i < held_n; i++) begin
                put_char(held_ws[i]);
            end
            held_n = 0;
            put_char(c);
            leading_only = 1'b0;
        end
    endfunction

    function automatic void text_in(logic [7:0] c);
        if (quote_peek) begin
            quote_peek = 1'b0;
            if (c == CH_QUOTE) begin
                put_char(c);
            end else begin
                in_string = 1'b0;
                plain_byte(c);
            end
        end else if (in_string) begin
            if (c == CH_QUOTE) begin
                quote_peek = 1'b1;
            end else begin
                put_char(c);
            end
        end else begin
            plain_byte(c);
        end
    endfunction

    function automatic void replay_bom();
        if (bom_pos == BOM_SAW_EF || bom_pos == BOM_SAW_EF_BB) begin
            text_in(BOM_BYTE0);
        end
        if (bom_pos == BOM_SAW_EF_BB) begin
            text_in(BOM_BYTE1);
        end
        bom_pos = BOM_PAST;
    endfunction

    function automatic void predict_transaction(logic m, logic [7:0] c);
        t_token tk;
        step_tokens.delete();
        if (m == MODE_EOT) begin
            replay_bom();
            quote_peek = 1'b0;
            in_string  = 1'b0;
            finish_row();
            reset_tracker();
        end else begin
            case (bom_pos)
                BOM_EXPECT_EF: begin
                    if (c == BOM_BYTE0) begin
                        bom_pos = BOM_SAW_EF;
                    end else begin
                        bom_pos = BOM_PAST;
                        text_in(c);
                    end
                end
                BOM_SAW_EF: begin
                    if (c == BOM_BYTE1) begin
                        bom_pos = BOM_SAW_EF_BB;
                    end else begin
                        replay_bom();
                        text_in(c);
                    end
                end
                BOM_SAW_EF_BB: begin
                    if (c == BOM_BYTE2) begin
                        bom_pos = BOM_PAST;
                    end else begin
                        replay_bom();
                        text_in(c);
                    end
                end
                default: begin
                    text_in(c);
                end
            endcase
        end
        foreach (step_tokens[i]) begin
            tk.res  = step_tokens[i];
            tk.last = (i == step_tokens.size() - 1);
            expected_tokens.insert(expected_tokens.size(), tk);
        end
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        fail_count++;
        if (fail_count <= MAX_PRINTED) begin
            $display("[%0t] token %0d: %s got 0x%0h, want 0x%0h",
                     $time, tokens_checked, what, got, want);
        end
    endtask

    task automatic check_token();
        t_token want;
        tokens_checked++;
        if (i_tok.trim_overflow === 1'b1) begin
            overflow_tokens++;
        end
        if (expected_tokens.size() == 0) begin
            report_mismatch("token with none pending, kind", i_tok.kind, 0);
            return;
        end
        want = expected_tokens.pop_front();
        if (i_tok.kind !== want.res.kind) begin
            report_mismatch("kind", i_tok.kind, want.res.kind);
        end
        if (i_tok.char_out !== want.res.char_out) begin
            report_mismatch("char_out", i_tok.char_out, want.res.char_out);
        end
        if (i_tok.field_was_quoted !== want.res.field_was_quoted) begin
            report_mismatch("field_was_quoted", i_tok.field_was_quoted,
                            want.res.field_was_quoted);
        end
        if (i_tok.trim_overflow !== want.res.trim_overflow) begin
            report_mismatch("trim_overflow", i_tok.trim_overflow, want.res.trim_overflow);
        end
        if (i_tok.last !== want.last) begin
            report_mismatch("last", i_tok.last, want.last);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_tracker();
            expected_tokens.delete();
        end else begin
            if (i_text.valid && i_text.ready) begin
                predict_transaction(i_text.mode, i_text.text_byte);
            end
            if (i_tok.valid && i_tok.ready) begin
                check_token();
            end
        end
        o_fail_count      <= fail_count;
        o_expected_left   <= expected_tokens.size();
        o_tokens_checked  <= tokens_checked;
        o_overflow_tokens <= overflow_tokens;
    end

endmodule

// ----- tb/sv/csv_byte_tokenizer_core_test.sv -----
// Testbench top for the CSV byte tokenizer: drives directed and random CSV documents
// with random idling on both channels and reports the verdict from the token checker.
// Depends on csvt_pkg, csvt_if, csv_byte_tokenizer_core and its checker module.
module csv_byte_tokenizer_core_test;
    import csvt_pkg::*;

    localparam int CLK_PERIOD     = 4;
    localparam int RESET_CYCLES   = 8;
    localparam int PENDING_DEPTH  = 16;
    localparam int ITEM_TARGET    = 380;
    localparam int HOLD_AT        = 140;
    localparam int PAUSE_AT       = 260;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 16;
    localparam int TIMEOUT_CYCLES = 600_000;
    localparam int MAX_GAP        = 16;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic [8:0] opening_text [30];
    int         sent_transactions;
    int         documents;
    int         fail_count;
    int         expected_left;
    int         tokens_checked;
    int         overflow_tokens;
    bit         in_calm;
    bit         out_calm;
    bit         hold_req;
    bit         hold_done;
    bit         pause_done;

    csvt_in_if  txt ();
    csvt_out_if tok ();

    csv_byte_tokenizer_core #(
        .MAX_PENDING_SPACE(PENDING_DEPTH)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_text (txt),
        .o_tok  (tok)
    );

    csv_byte_tokenizer_core_checker #(
        .MAX_PENDING_SPACE(PENDING_DEPTH)
    ) u_token_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_text           (txt),
        .i_tok            (tok),
        .o_fail_count     (fail_count),
        .o_expected_left  (expected_left),
        .o_tokens_checked (tokens_checked),
        .o_overflow_tokens(overflow_tokens)
    );

    always begin
        #(CLK_PERIOD / 2) i_clk = 1'b1;
        #(CLK_PERIOD / 2) i_clk = 1'b0;
    end

    function automatic int next_gap(inout bit calm);
        if ($urandom_range(0, 31) == 0) begin
            calm = !calm;
        end
        return calm ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    function automatic logic [7:0] blank_byte();
        case ($urandom_range(0, 3))
            0: return CH_SPACE;
            1: return CH_HT;
            2: return CH_VT;
            default: return CH_FF;
        endcase
    endfunction

    function automatic logic [7:0] field_byte(input bit quoted);
        logic [7:0] b;
        if ($urandom_range(0, 1) == 1) begin
            return 8'("a" + $urandom_range(0, 25));
        end
        do begin
            b = 8'($urandom_range(0, 255));
        end while (b == CH_QUOTE || (!quoted && (b inside {CH_COMMA, CH_LF, CH_CR,
                                                           CH_SPACE, CH_HT, CH_VT, CH_FF})));
        return b;
    endfunction

    task automatic send_item(input logic m, input logic [7:0] b);
        int gap;
        gap = next_gap(in_calm);
        if (gap > 0) begin
            txt.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        txt.valid     <= 1'b1;
        txt.mode      <= m;
        txt.text_byte <= b;
        do @(posedge i_clk); while (!txt.ready);
        sent_transactions++;
        if (m == MODE_EOT) begin
            documents++;
        end
    endtask

    task automatic drain_tokens();
        txt.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_left != 0) @(posedge i_clk);
    endtask

    // long runs can overflow the trim buffer
    task automatic send_blanks();
        int n;
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(14, 22) : $urandom_range(1, 3);
        repeat (n) send_item(MODE_TEXT, blank_byte());
    endtask

    task automatic send_field();
        int pick;
        repeat ($urandom_range(0, 2)) send_item(MODE_TEXT, blank_byte());
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
            send_item(MODE_TEXT, CH_QUOTE);
            repeat ($urandom_range(0, 6)) begin
                case ($urandom_range(0, 5))
                    0: begin
                        send_item(MODE_TEXT, CH_QUOTE);
                        send_item(MODE_TEXT, CH_QUOTE);
                    end
                    1: send_item(MODE_TEXT, CH_COMMA);
                    2: send_item(MODE_TEXT, ($urandom_range(0, 1) == 1) ? CH_LF : CH_CR);
                    3: send_item(MODE_TEXT, blank_byte());
                    default: send_item(MODE_TEXT, field_byte(1'b1));
                endcase
            end
            send_item(MODE_TEXT, CH_QUOTE);
            if ($urandom_range(0, 4) == 0) begin
                send_blanks();
                send_item(MODE_TEXT, ($urandom_range(0, 1) == 1) ? CH_QUOTE : field_byte(1'b0));
            end
        end else if (pick < 9) begin
            repeat ($urandom_range(1, 5)) begin
                send_item(MODE_TEXT, field_byte(1'b0));
                if ($urandom_range(0, 9) == 0) begin
                    send_item(MODE_TEXT, CH_QUOTE);
                end
                if ($urandom_range(0, 2) == 0) begin
                    send_blanks();
                end
            end
        end
    endtask

    task automatic send_row();
        int fields;
        fields = $urandom_range(1, 4);
        for (int f = 0; f < fields; f++) begin
            if (f > 0) begin
                send_item(MODE_TEXT, CH_COMMA);
            end
            send_field();
        end
        if ($urandom_range(0, 2) == 0) begin
            send_item(MODE_TEXT, CH_CR);
        end
        send_item(MODE_TEXT, CH_LF);
    endtask

    task automatic send_document();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick < 3) begin
            send_item(MODE_TEXT, BOM_BYTE0);
        end
        if (pick < 2) begin
            send_item(MODE_TEXT, BOM_BYTE1);
        end
        if (pick < 1) begin
            send_item(MODE_TEXT, BOM_BYTE2);
        end
        repeat ($urandom_range(0, 3)) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                repeat ($urandom_range(1, 12)) send_item(MODE_TEXT, 8'($urandom_range(0, 255)));
            end else if (pick == 1) begin
                send_item(MODE_TEXT, CH_LF);
            end else begin
                send_row();
            end
        end
        if ($urandom_range(0, 3) == 0) begin
            send_field();
        end
        send_item(MODE_EOT, 8'($urandom_range(0, 255)));
    endtask

    initial begin
        i_rst_n       = 1'b0;
        txt.valid     = 1'b0;
        txt.mode      = MODE_TEXT;
        txt.text_byte = 8'h00;
        opening_text  = '{
            {MODE_TEXT, BOM_BYTE0}, {MODE_TEXT, BOM_BYTE1}, {MODE_TEXT, BOM_BYTE2},
            {MODE_TEXT, CH_SPACE},  {MODE_TEXT, CH_QUOTE},  {MODE_TEXT, "a"},
            {MODE_TEXT, CH_QUOTE},  {MODE_TEXT, CH_QUOTE},  {MODE_TEXT, CH_QUOTE},
            {MODE_TEXT, "x"},       {MODE_TEXT, CH_QUOTE},  {MODE_TEXT, CH_COMMA},
            {MODE_TEXT, "b"},       {MODE_TEXT, CH_QUOTE},  {MODE_TEXT, CH_HT},
            {MODE_TEXT, "c"},       {MODE_TEXT, CH_CR},     {MODE_TEXT, CH_LF},
            {MODE_TEXT, CH_LF},     {MODE_TEXT, CH_QUOTE},  {MODE_TEXT, "d"},
            {MODE_TEXT, CH_QUOTE},  {MODE_EOT, 8'hFF},      {MODE_TEXT, BOM_BYTE0},
            {MODE_TEXT, BOM_BYTE1}, {MODE_TEXT, 8'h00},     {MODE_EOT, 8'h00},
            {MODE_TEXT, CH_QUOTE},  {MODE_TEXT, 8'hFF},     {MODE_EOT, 8'h00}
        };
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (opening_text[i]) begin
            send_item(opening_text[i][8], opening_text[i][7:0]);
        end
        drain_tokens();
        while (sent_transactions < ITEM_TARGET) begin
            if (sent_transactions >= HOLD_AT && !hold_done) begin
                hold_done = 1'b1;
                hold_req  = 1'b1;
            end
            if (sent_transactions >= PAUSE_AT && !pause_done) begin
                pause_done = 1'b1;
                drain_tokens();
            end
            send_document();
        end
        drain_tokens();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Covered %0d text transactions in %0d documents, %0d tokens checked,",
                 sent_transactions, documents, tokens_checked);
        $display("%0d of them whitespace pushed out of a full trim buffer.", overflow_tokens);
        if (fail_count == 0 && expected_left == 0) begin
            $display("[csv_byte_tokenizer_core] OK");
        end else begin
            $display("[csv_byte_tokenizer_core] ERROR");
        end
        $finish;
    end

    initial begin : token_sink
        int stall;
        tok.ready = 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                tok.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            stall = next_gap(out_calm);
            if (stall > 0) begin
                tok.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            tok.ready <= 1'b1;
            do @(posedge i_clk); while (!(tok.valid && tok.ready));
        end
    end

    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("[csv_byte_tokenizer_core] ERROR");
        $finish;
    end

endmodule

// ----- csv_byte_tokenizer_core.f -----
rtl/csvt_pkg.sv
rtl/csvt_if.sv
rtl/csvt_ram.sv
rtl/csvt_queue.sv
rtl/csvt_front.sv
rtl/csvt_back.sv
rtl/csvt_emit.sv
rtl/csv_byte_tokenizer_core.sv
tb/sv/csv_byte_tokenizer_core_checker.sv
tb/sv/csv_byte_tokenizer_core_test.sv
